FILE: sv/pta_pkg.sv
package pta_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int WIDE_W     = 21;

    localparam logic [1:0] OP_ALLOC_ONE     = 2'd0;
    localparam logic [1:0] OP_ALLOC_RUN     = 2'd1;
    localparam logic [1:0] OP_ALLOC_SCATTER = 2'd2;
    localparam logic [1:0] OP_MAP_RANGE     = 2'd3;

    typedef logic [WIDE_W-1:0] wide_idx_t;

endpackage

FILE: sv/pta_ram.sv
module pta_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/page_table_allocator_top.sv
// channel   signals                                                      direction
// input     in_valid, in_stall, operation, entry_flags, page_count,
//           start_address, end_address                                   in (stall out)
// output    out_valid, out_stall, result_address, status                 out (stall in)
//
// an operation scans the present bits, reading one per cycle, then alloc_run writes its
// run one entry per cycle, plus issue and finish; map_range writes its range without a scan
// after reset a clearing pass marks every entry not present and holds in_stall high
// in_stall is high whenever an operation is in progress
// a finished result waits in the output register while a new item is taken
module page_table_allocator_top #(
    parameter int NUM_PAGES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [11:0] entry_flags,
    input  logic [10:0] page_count,
    input  logic [31:0] start_address,
    input  logic [31:0] end_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_address,
    output logic        status
);

    import pta_pkg::*;

    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W = $clog2(NUM_PAGES + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             chk_v_reg, chk_v_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [10:0]      run_reg, run_next;
    logic [31:0]      next_reg, next_next;
    wide_idx_t        wr_idx_reg, wr_idx_next;
    wide_idx_t        wr_end_reg, wr_end_next;
    logic [1:0]       op_reg, op_next;
    logic             pres_reg, pres_next;
    logic [10:0]      cnt_reg, cnt_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      end_reg, end_next;
    logic [31:0]      res_addr_reg, res_addr_next;
    logic             res_fail_reg, res_fail_next;
    logic             out_v_reg, out_v_next;
    logic [31:0]      out_addr_reg, out_addr_next;
    logic             out_fail_reg, out_fail_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_rdata;

    logic             ent_free;
    logic             last_chk;
    logic [10:0]      run_inc;
    logic [31:0]      next_after;
    wide_idx_t        first_idx;
    wide_idx_t        lo_idx;
    wide_idx_t        hi_idx;

    pta_ram #(
        .WIDTH(1),
        .DEPTH(NUM_PAGES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ent_free   = ~ram_rdata;
    assign last_chk   = (chk_idx_reg == IDX_W'(NUM_PAGES - 1));
    assign run_inc    = ent_free ? (run_reg + 11'd1) : 11'd0;
    assign next_after = (ent_free && (next_reg < end_reg)) ? (next_reg + 32'd4096) : next_reg;
    assign first_idx  = WIDE_W'(chk_idx_reg) + WIDE_W'(1) - WIDE_W'(cnt_reg);
    assign lo_idx     = WIDE_W'(start_address >> PAGE_SHIFT);
    assign hi_idx     = ((end_address >> PAGE_SHIFT) > 32'(NUM_PAGES))
                        ? WIDE_W'(NUM_PAGES) : WIDE_W'(end_address >> PAGE_SHIFT);
    assign ram_raddr  = idx_reg[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        chk_v_next    = 1'b0;
        chk_idx_next  = chk_idx_reg;
        run_next      = run_reg;
        next_next     = next_reg;
        wr_idx_next   = wr_idx_reg;
        wr_end_next   = wr_end_reg;
        op_next       = op_reg;
        pres_next     = pres_reg;
        cnt_next      = cnt_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        res_addr_next = res_addr_reg;
        res_fail_next = res_fail_reg;
        out_v_next    = out_v_reg && out_stall;
        out_addr_next = out_addr_reg;
        out_fail_next = out_fail_reg;
        ram_we        = 1'b0;
        ram_waddr     = chk_idx_reg;
        ram_wdata     = pres_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = 1'b0;
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = operation;
                    pres_next     = entry_flags[0];
                    cnt_next      = page_count;
                    start_next    = start_address;
                    end_next      = end_address;
                    next_next     = start_address;
                    run_next      = 11'd0;
                    idx_next      = '0;
                    res_addr_next = 32'd0;
                    res_fail_next = 1'b1;
                    state_next    = S_SCAN;
                    if (operation == OP_ALLOC_RUN && page_count == 11'd0)
                    begin
                        res_fail_next = 1'b0;
                        state_next    = S_FIN;
                    end
                    else if (operation == OP_MAP_RANGE)
                    begin
                        res_addr_next = start_address;
                        res_fail_next = 1'b0;
                        wr_idx_next   = lo_idx;
                        wr_end_next   = hi_idx;
                        state_next    = (lo_idx < hi_idx) ? S_WRITE : S_FIN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg < CNT_W'(NUM_PAGES))
                begin
                    chk_v_next   = 1'b1;
                    chk_idx_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                if (chk_v_reg)
                begin
                    case (op_reg)
                        OP_ALLOC_ONE:
                        begin
                            if (ent_free)
                            begin
                                ram_we        = 1'b1;
                                res_addr_next = 32'(chk_idx_reg) << PAGE_SHIFT;
                                res_fail_next = 1'b0;
                                state_next    = S_FIN;
                            end
                            else if (last_chk)
                            begin
                                state_next = S_FIN;
                            end
                        end
                        OP_ALLOC_RUN:
                        begin
                            run_next = run_inc;
                            if (run_inc == cnt_reg)
                            begin
                                wr_idx_next   = first_idx;
                                wr_end_next   = WIDE_W'(chk_idx_reg) + WIDE_W'(1);
                                res_addr_next = 32'(first_idx) << PAGE_SHIFT;
                                res_fail_next = 1'b0;
                                state_next    = S_WRITE;
                            end
                            else if (last_chk)
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            next_next = next_after;
                            if (next_reg >= end_reg)
                            begin
                                res_addr_next = start_reg;
                                res_fail_next = 1'b0;
                                state_next    = S_FIN;
                            end
                            else
                            begin
                                ram_we = ent_free;
                                if (last_chk)
                                begin
                                    res_fail_next = ~(next_after >= end_reg);
                                    res_addr_next = (next_after >= end_reg) ? start_reg : 32'd0;
                                    state_next    = S_FIN;
                                end
                            end
                        end
                    endcase
                end
                if (state_next != S_SCAN)
                begin
                    chk_v_next = 1'b0;
                end
            end
            S_WRITE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = wr_idx_reg[IDX_W-1:0];
                wr_idx_next = wr_idx_reg + WIDE_W'(1);
                if (wr_idx_next == wr_end_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_v_reg || !out_stall)
                begin
                    out_v_next    = 1'b1;
                    out_addr_next = res_addr_reg;
                    out_fail_next = res_fail_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            chk_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            chk_v_reg <= chk_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        run_reg      <= run_next;
        next_reg     <= next_next;
        wr_idx_reg   <= wr_idx_next;
        wr_end_reg   <= wr_end_next;
        op_reg       <= op_next;
        pres_reg     <= pres_next;
        cnt_reg      <= cnt_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        res_addr_reg <= res_addr_next;
        res_fail_reg <= res_fail_next;
        out_addr_reg <= out_addr_next;
        out_fail_reg <= out_fail_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_v_reg;
    assign result_address = out_addr_reg;
    assign status         = out_fail_reg;

endmodule
